// ===== hw/rtl/pcrc_pkg.sv =====
package pcrc_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_OK    = 2'd1,
    ST_BAD   = 2'd2,
    ST_SHORT = 2'd3
  } status_t;

  // One result.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eop;
    status_t    status;
  } result_t;

  // Up to three results caused by one request, slot 0 first.
  typedef struct packed {
    logic [1:0]        cnt;
    result_t [2:0]     item;
  } res_set_t;

  // Eight shifts of the register, then the byte goes into the low bits.
  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] v;
    v = c;
    for (int i = 0; i < 8; i++) begin
      if (v[15]) begin
        v = {v[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v ^ {8'h00, d};
  endfunction

  function automatic result_t mk_res(input logic [7:0] d, input logic vld, input logic eop,
                                     input status_t st);
    result_t r;
    r.data   = vld ? d : 8'h00;
    r.valid  = vld;
    r.eop    = eop;
    r.status = st;
    return r;
  endfunction

endpackage

// ===== hw/rtl/packet_crc16_append_check.sv =====
// Channel  | Ports                                                  | Dir
// ---------+--------------------------------------------------------+-----
// input    | in_valid/in_ready, in_data_byte, in_is_last, in_has_crc | in
// result   | out_valid/out_ready, out_byte, out_byte_valid,          | out
//          | out_end_of_packet, out_check_status                     |
// config   | cfg_we, cfg_check_mode                                  | in
//
// Flow: while out_ready is high, requests giving zero or one result let
// bytes stream at one per clock. Requests giving two or three results
// (held-byte flush, CRC append) hold in_ready low until one result is left
// and out_ready is high: the three-slot buffer drains one result per clock.
// Reset (rst_n low, synchronous) clears mode, CRC, delay line and buffer.
// Results are registered; a stalled out_ready backs up into in_ready.
module packet_crc16_append_check (
  input  logic       clk,
  input  logic       rst_n,
  // config
  input  logic       cfg_we,
  input  logic       cfg_check_mode,
  // input requests
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_last,
  input  logic       in_has_crc,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_end_of_packet,
  output logic [1:0] out_check_status
);

  pcrc_pkg::res_set_t res;
  pcrc_pkg::result_t  head;
  logic               accept;
  logic               can_load;

  assign in_ready = can_load;
  assign accept   = in_valid && in_ready;

  // CRC state, delay line and per-request result set
  pcrc_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_check_mode (cfg_check_mode),
    .accept         (accept),
    .in_data_byte   (in_data_byte),
    .in_is_last     (in_is_last),
    .in_has_crc     (in_has_crc),
    .res            (res)
  );

  // result register, one result out per cycle while out_ready is high
  pcrc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res       (res),
    .out_ready (out_ready),
    .can_load  (can_load),
    .out_valid (out_valid),
    .head      (head)
  );

  assign out_byte          = head.data;
  assign out_byte_valid    = head.valid;
  assign out_end_of_packet = head.eop;
  assign out_check_status  = head.status;

endmodule

// ===== hw/rtl/pcrc_core.sv =====
// Packet state and per-request result generation.
module pcrc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_check_mode,
  input  logic                accept,
  input  logic [7:0]          in_data_byte,
  input  logic                in_is_last,
  input  logic                in_has_crc,
  output pcrc_pkg::res_set_t  res
);

  logic        mode_r,   mode_nxt;
  logic [15:0] crc_r,    crc_nxt;
  logic [7:0]  older_r,  older_nxt;
  logic [7:0]  newer_r,  newer_nxt;
  logic [1:0]  held_r,   held_nxt;

  logic [15:0] crc_b;
  logic [15:0] crc_o;
  logic [15:0] rx;

  assign crc_b = pcrc_pkg::crc_update(crc_r, in_data_byte);
  assign crc_o = pcrc_pkg::crc_update(crc_r, older_r);
  assign rx    = {in_data_byte, newer_r};

  always_comb begin
    mode_nxt  = mode_r;
    crc_nxt   = crc_r;
    older_nxt = older_r;
    newer_nxt = newer_r;
    held_nxt  = held_r;
    res       = '0;

    if (cfg_we) begin
      mode_nxt  = cfg_check_mode;
      crc_nxt   = '0;
      older_nxt = '0;
      newer_nxt = '0;
      held_nxt  = '0;
    end else if (accept) begin
      if (!in_has_crc) begin
        // flush held bytes ahead of the current byte
        if (held_r >= 2'd2) begin
          res.cnt     = 2'd3;
          res.item[0] = pcrc_pkg::mk_res(older_r, 1'b1, 1'b0, pcrc_pkg::ST_NONE);
          res.item[1] = pcrc_pkg::mk_res(newer_r, 1'b1, 1'b0, pcrc_pkg::ST_NONE);
          res.item[2] = pcrc_pkg::mk_res(in_data_byte, 1'b1, in_is_last, pcrc_pkg::ST_NONE);
        end else if (held_r == 2'd1) begin
          res.cnt     = 2'd2;
          res.item[0] = pcrc_pkg::mk_res(newer_r, 1'b1, 1'b0, pcrc_pkg::ST_NONE);
          res.item[1] = pcrc_pkg::mk_res(in_data_byte, 1'b1, in_is_last, pcrc_pkg::ST_NONE);
        end else begin
          res.cnt     = 2'd1;
          res.item[0] = pcrc_pkg::mk_res(in_data_byte, 1'b1, in_is_last, pcrc_pkg::ST_NONE);
        end
        if (held_r != 2'd0 || in_is_last) begin
          crc_nxt   = '0;
          older_nxt = '0;
          newer_nxt = '0;
          held_nxt  = '0;
        end
      end else if (!mode_r) begin
        // generate: pass through, append CRC low then high on last
        res.item[0] = pcrc_pkg::mk_res(in_data_byte, 1'b1, 1'b0, pcrc_pkg::ST_NONE);
        if (in_is_last) begin
          res.cnt     = 2'd3;
          res.item[1] = pcrc_pkg::mk_res(crc_b[7:0], 1'b1, 1'b0, pcrc_pkg::ST_NONE);
          res.item[2] = pcrc_pkg::mk_res(crc_b[15:8], 1'b1, 1'b1, pcrc_pkg::ST_NONE);
          crc_nxt     = '0;
          older_nxt   = '0;
          newer_nxt   = '0;
          held_nxt    = '0;
        end else begin
          res.cnt = 2'd1;
          crc_nxt = crc_b;
        end
      end else if (!in_is_last) begin
        // check: two-byte delay line
        if (held_r >= 2'd2) begin
          res.cnt     = 2'd1;
          res.item[0] = pcrc_pkg::mk_res(older_r, 1'b1, 1'b0, pcrc_pkg::ST_NONE);
          crc_nxt     = crc_o;
          older_nxt   = newer_r;
          newer_nxt   = in_data_byte;
        end else if (held_r == 2'd1) begin
          older_nxt = newer_r;
          newer_nxt = in_data_byte;
          held_nxt  = 2'd2;
        end else begin
          newer_nxt = in_data_byte;
          held_nxt  = 2'd1;
        end
      end else begin
        res.cnt = 2'd1;
        if (held_r == 2'd0) begin
          res.item[0] = pcrc_pkg::mk_res(8'h00, 1'b0, 1'b1, pcrc_pkg::ST_SHORT);
        end else if (held_r >= 2'd2) begin
          res.item[0] = pcrc_pkg::mk_res(older_r, 1'b1, 1'b1,
                          (rx == crc_o) ? pcrc_pkg::ST_OK : pcrc_pkg::ST_BAD);
        end else begin
          res.item[0] = pcrc_pkg::mk_res(8'h00, 1'b0, 1'b1,
                          (rx == crc_r) ? pcrc_pkg::ST_OK : pcrc_pkg::ST_BAD);
        end
        crc_nxt   = '0;
        older_nxt = '0;
        newer_nxt = '0;
        held_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      crc_r   <= '0;
      older_r <= '0;
      newer_r <= '0;
      held_r  <= '0;
    end else begin
      mode_r  <= mode_nxt;
      crc_r   <= crc_nxt;
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ===== hw/rtl/pcrc_outq.sv =====
// Three-slot result buffer, drained one result per cycle while out_ready is high.
module pcrc_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  pcrc_pkg::res_set_t  res,
  input  logic                out_ready,
  output logic                can_load,
  output logic                out_valid,
  output pcrc_pkg::result_t   head
);

  pcrc_pkg::result_t [2:0] slot_r;
  logic [1:0]              cnt_r;
  logic                    pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign head      = slot_r[0];
  // take a new request once the buffer empties this cycle
  assign can_load  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= res.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= res.item;
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

endmodule
